// ===== rtl/stac_pkg.sv =====
// Shared constants, types and helper functions for the survey traverse accumulator.
// Used by every module of the block; depends on nothing else.

package stac_pkg;

    localparam int COORD_FRAC_BITS = 8;
    localparam int CORDIC_STEPS    = 20;

    // Shot kinds on the input and result channels.
    localparam logic [1:0] KIND_LEG   = 2'd0;
    localparam logic [1:0] KIND_SPLAY = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam int POS_W  = 40;
    localparam int CNT_W  = 16;
    localparam int DIST_W = 21;   // distance in centimetres times 30

    // CORDIC datapath, Q30 angles and values.
    localparam int ANG_W  = 33;
    localparam int ITER_W = $clog2(CORDIC_STEPS);
    localparam logic signed [ANG_W-1:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic [29:0] ATAN_TAB [0:9] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
        30'd33543516,  30'd16775851,  30'd8388437,   30'd4194283,   30'd2097149
    };

    // Serial multiplier.
    localparam int MUL_A_W   = 35;
    localparam int MUL_B_W   = 32;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);
    localparam logic [MUL_A_W-1:0] DEG_TO_RAD_Q46 = 35'd12281662764;

    // Offset scaling: divide by 100 * 2^OFF_SHIFT with rounding.
    localparam int CM_PER_M   = 100;
    localparam int OFF_SHIFT  = 30 - COORD_FRAC_BITS;
    localparam int OFF_SUM_W  = 54;
    localparam int DIV_W      = 53 - OFF_SHIFT;
    localparam int DIV_CNT_W  = $clog2(DIV_W);
    localparam int REM_W      = 7;
    localparam logic [OFF_SUM_W-1:0] OFF_HALF = OFF_SUM_W'(CM_PER_M / 2) << OFF_SHIFT;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ZP,
        S_CORP,
        S_ZW,
        S_CORW,
        S_HX,
        S_HY,
        S_OMUL,
        S_ODIV,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [13:0] mag;
        logic        neg;
        logic        flip;
    } angle_t;

    // Brings an angle in hundredths of a degree into [-9000, 9000]; flip marks
    // that sine and cosine must both be negated.
    function automatic angle_t reduce_angle(input logic signed [17:0] cdeg);
        logic signed [17:0] r;
        angle_t             res;
        r        = cdeg;
        res.flip = 1'b0;
        if (r >= 18'sd36000)
            r = r - 18'sd36000;
        if (r < 18'sd0)
            r = r + 18'sd36000;
        if (r > 18'sd18000)
            r = r - 18'sd36000;
        if (r > 18'sd9000)
        begin
            r        = r - 18'sd18000;
            res.flip = 1'b1;
        end
        else if (r < -18'sd9000)
        begin
            r        = r + 18'sd18000;
            res.flip = 1'b1;
        end
        res.neg = r[17];
        res.mag = r[17] ? 14'(-r) : 14'(r);
        return res;
    endfunction

    function automatic logic [ANG_W-1:0] atan_q30(input logic [4:0] i);
        logic [ANG_W-1:0] v;
        if (i < 5'd10)
            v = ANG_W'(ATAN_TAB[i[3:0]]);
        else if (i <= 5'd30)
            v = ANG_W'(1) << (5'd30 - i);
        else
            v = '0;
        return v;
    endfunction

    function automatic logic [MUL_B_W-1:0] mag32(input logic signed [ANG_W-1:0] v);
        return v[ANG_W-1] ? MUL_B_W'(-v) : MUL_B_W'(v);
    endfunction

endpackage

// ===== rtl/survey_traverse_accumulator_unit.sv =====
// Survey traverse accumulator: one shot in, one point out per leg, splay or clear.
// A leg or splay runs seven serial multiplies, two CORDIC runs and three divides by 100,
// all on one shared unit each; a clear goes straight to its result.
// One shot is in work at a time, so a new shot is taken only once the last result has
// moved to the output register, where a finished result waits. Reset clears the station.

module survey_traverse_accumulator_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         kind,
    input  logic [15:0]                        distance_cm,
    input  logic signed [14:0]                 pitch_cdeg,
    input  logic [15:0]                        yaw_cdeg,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         point_kind,
    output logic signed [stac_pkg::POS_W-1:0]  pos_x,
    output logic signed [stac_pkg::POS_W-1:0]  pos_y,
    output logic signed [stac_pkg::POS_W-1:0]  pos_z,
    output logic [stac_pkg::CNT_W-1:0]         station_number
);
    import stac_pkg::*;

    state_t                  state_reg, state_next;
    logic                    phase_reg, phase_next;
    logic [1:0]              comp_reg;
    logic [1:0]              kind_reg;
    logic [DIST_W-1:0]       dist30_reg;
    angle_t                  ap_reg, aw_reg;
    logic signed [ANG_W-1:0] sp_reg, cp_reg, sw_reg, cw_reg;
    logic [ANG_W-1:0]        hx_mag_reg, hy_mag_reg;
    logic                    hx_neg_reg, hy_neg_reg;
    logic signed [POS_W-1:0] res_x_reg, res_y_reg, res_z_reg;
    logic signed [POS_W-1:0] st_x_reg, st_y_reg, st_z_reg;
    logic [CNT_W-1:0]        count_reg;
    logic                    out_valid_reg;
    logic [1:0]              point_kind_reg;
    logic signed [POS_W-1:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic [CNT_W-1:0]        station_number_reg;

    logic                    accept;
    logic                    fire;
    logic                    mul_start, cor_start, div_start;
    logic                    mul_done, cor_done, div_done;
    logic [MUL_A_W-1:0]      mul_a;
    logic [MUL_B_W-1:0]      mul_b;
    logic [MUL_P_W-1:0]      mul_p;
    logic signed [ANG_W-1:0] cor_cos, cor_sin;
    logic [DIV_W-1:0]        div_q;
    logic                    unit_done;

    logic [47:0]             z_sum;
    logic signed [ANG_W-1:0] z_val;
    logic                    z_neg;
    logic [62:0]             h_sum;
    logic [OFF_SUM_W-1:0]    off_sum;
    logic [ANG_W-1:0]        fac_mag;
    logic                    fac_neg;
    logic signed [POS_W:0]   off_ext, base_ext, pos_sum;
    logic signed [POS_W-1:0] pos_sat;
    logic [CNT_W-1:0]        count_inc;

    assign accept = (state_reg == S_IDLE) && in_valid;
    assign fire   = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                phase_next = 1'b0;
                if (in_valid)
                begin
                    if (kind == KIND_CLEAR)
                        state_next = S_DONE;
                    else if (kind == KIND_LEG || kind == KIND_SPLAY)
                        state_next = S_ZP;
                end
            end
            S_DONE:
            begin
                if (fire)
                    state_next = S_IDLE;
            end
            default:
            begin
                // Every working state issues its unit once, then waits for done.
                if (!phase_reg)
                    phase_next = 1'b1;
                else if (unit_done)
                begin
                    phase_next = 1'b0;
                    unique case (state_reg)
                        S_ZP:    state_next = S_CORP;
                        S_CORP:  state_next = S_ZW;
                        S_ZW:    state_next = S_CORW;
                        S_CORW:  state_next = S_HX;
                        S_HX:    state_next = S_HY;
                        S_HY:    state_next = S_OMUL;
                        S_OMUL:  state_next = S_ODIV;
                        S_ODIV:  state_next = (comp_reg == 2'd2) ? S_DONE : S_OMUL;
                        default: state_next = S_IDLE;
                    endcase
                end
            end
        endcase
    end

    // Unit control and operand selection.
    always_comb
    begin
        mul_start = 1'b0;
        cor_start = 1'b0;
        div_start = 1'b0;
        unit_done = mul_done;
        mul_a     = '0;
        mul_b     = '0;
        unique case (state_reg)
            S_ZP:
            begin
                mul_start = !phase_reg;
                mul_a     = DEG_TO_RAD_Q46;
                mul_b     = MUL_B_W'(ap_reg.mag);
            end
            S_ZW:
            begin
                mul_start = !phase_reg;
                mul_a     = DEG_TO_RAD_Q46;
                mul_b     = MUL_B_W'(aw_reg.mag);
            end
            S_HX:
            begin
                mul_start = !phase_reg;
                mul_a     = MUL_A_W'(mag32(cp_reg));
                mul_b     = mag32(cw_reg);
            end
            S_HY:
            begin
                mul_start = !phase_reg;
                mul_a     = MUL_A_W'(mag32(cp_reg));
                mul_b     = mag32(sw_reg);
            end
            S_OMUL:
            begin
                mul_start = !phase_reg;
                mul_a     = MUL_A_W'(fac_mag);
                mul_b     = MUL_B_W'(dist30_reg);
            end
            S_CORP, S_CORW:
            begin
                cor_start = !phase_reg;
                unit_done = cor_done;
            end
            S_ODIV:
            begin
                div_start = !phase_reg;
                unit_done = div_done;
            end
            default:
            begin
                unit_done = 1'b0;
            end
        endcase
    end

    // Angle in Q30 radians, rounded to nearest with ties away from zero.
    assign z_neg   = (state_reg == S_CORP) ? ap_reg.neg : aw_reg.neg;
    assign z_sum   = mul_p[47:0] + 48'h8000;
    assign z_val   = z_neg ? -$signed({1'b0, z_sum[47:16]}) : $signed({1'b0, z_sum[47:16]});

    assign h_sum   = mul_p[62:0] + (63'd1 << 29);

    always_comb
    begin
        unique case (comp_reg)
            2'd0:
            begin
                fac_mag = hx_mag_reg;
                fac_neg = hx_neg_reg;
            end
            2'd1:
            begin
                fac_mag = hy_mag_reg;
                fac_neg = hy_neg_reg;
            end
            default:
            begin
                fac_mag = ANG_W'(mag32(sp_reg));
                fac_neg = sp_reg[ANG_W-1];
            end
        endcase
    end

    assign off_sum = mul_p[OFF_SUM_W-1:0] + OFF_HALF;

    always_comb
    begin
        unique case (comp_reg)
            2'd0:    base_ext = (POS_W + 1)'(st_x_reg);
            2'd1:    base_ext = (POS_W + 1)'(st_y_reg);
            default: base_ext = (POS_W + 1)'(st_z_reg);
        endcase
    end

    assign off_ext = fac_neg ? -$signed((POS_W + 1)'(div_q)) : $signed((POS_W + 1)'(div_q));
    assign pos_sum = base_ext + off_ext;

    always_comb
    begin
        if (pos_sum[POS_W] != pos_sum[POS_W-1])
            pos_sat = pos_sum[POS_W] ? {1'b1, {(POS_W - 1){1'b0}}} : {1'b0, {(POS_W - 1){1'b1}}};
        else
            pos_sat = pos_sum[POS_W-1:0];
    end

    assign count_inc = (count_reg == {CNT_W{1'b1}}) ? count_reg : count_reg + 1'b1;

    stac_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    stac_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .z_in    (z_val),
        .done    (cor_done),
        .cos_out (cor_cos),
        .sin_out (cor_sin)
    );

    stac_div100 u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .n     (off_sum[OFF_SHIFT +: DIV_W]),
        .done  (div_done),
        .q     (div_q)
    );

    // Control state, the station and the output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= 1'b0;
            comp_reg      <= '0;
            out_valid_reg <= 1'b0;
            st_x_reg      <= '0;
            st_y_reg      <= '0;
            st_z_reg      <= '0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            if (accept)
                comp_reg <= '0;
            else if (state_reg == S_ODIV && phase_reg && div_done)
                comp_reg <= comp_reg + 1'b1;

            if (fire)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (fire && kind_reg == KIND_CLEAR)
            begin
                st_x_reg  <= '0;
                st_y_reg  <= '0;
                st_z_reg  <= '0;
                count_reg <= '0;
            end
            else if (fire && kind_reg == KIND_LEG)
            begin
                st_x_reg  <= res_x_reg;
                st_y_reg  <= res_y_reg;
                st_z_reg  <= res_z_reg;
                count_reg <= count_inc;
            end
        end
    end

    // Working values and the result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= kind;
            dist30_reg <= (DIST_W'(distance_cm) << 5) - (DIST_W'(distance_cm) << 1);
            ap_reg     <= reduce_angle(18'(pitch_cdeg));
            aw_reg     <= reduce_angle($signed({2'b00, yaw_cdeg}));
        end

        if (phase_reg && cor_done && state_reg == S_CORP)
        begin
            sp_reg <= ap_reg.flip ? -cor_sin : cor_sin;
            cp_reg <= ap_reg.flip ? -cor_cos : cor_cos;
        end
        if (phase_reg && cor_done && state_reg == S_CORW)
        begin
            sw_reg <= aw_reg.flip ? -cor_sin : cor_sin;
            cw_reg <= aw_reg.flip ? -cor_cos : cor_cos;
        end
        if (phase_reg && mul_done && state_reg == S_HX)
        begin
            hx_mag_reg <= h_sum[62:30];
            hx_neg_reg <= cp_reg[ANG_W-1] ^ cw_reg[ANG_W-1];
        end
        if (phase_reg && mul_done && state_reg == S_HY)
        begin
            hy_mag_reg <= h_sum[62:30];
            hy_neg_reg <= cp_reg[ANG_W-1] ^ sw_reg[ANG_W-1];
        end
        if (phase_reg && div_done && state_reg == S_ODIV)
        begin
            unique case (comp_reg)
                2'd0:    res_x_reg <= pos_sat;
                2'd1:    res_y_reg <= pos_sat;
                default: res_z_reg <= pos_sat;
            endcase
        end

        if (fire)
        begin
            point_kind_reg <= kind_reg;
            if (kind_reg == KIND_CLEAR)
            begin
                pos_x_reg          <= '0;
                pos_y_reg          <= '0;
                pos_z_reg          <= '0;
                station_number_reg <= '0;
            end
            else
            begin
                pos_x_reg          <= res_x_reg;
                pos_y_reg          <= res_y_reg;
                pos_z_reg          <= res_z_reg;
                station_number_reg <= (kind_reg == KIND_LEG) ? count_inc : count_reg;
            end
        end
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign point_kind     = point_kind_reg;
    assign pos_x          = pos_x_reg;
    assign pos_y          = pos_y_reg;
    assign pos_z          = pos_z_reg;
    assign station_number = station_number_reg;

endmodule

// ===== rtl/stac_mul.sv =====
// Shift-and-add multiplier that scans one multiplier bit per cycle.
// Depends on stac_pkg.

module stac_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [stac_pkg::MUL_A_W-1:0]  a,
    input  logic [stac_pkg::MUL_B_W-1:0]  b,
    output logic                          done,
    output logic [stac_pkg::MUL_P_W-1:0]  p
);
    import stac_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic [MUL_A_W-1:0]   a_reg;
    logic [MUL_P_W-1:0]   prod_reg;
    logic [MUL_A_W:0]     sum;
    logic [MUL_P_W-1:0]   prod_next;

    // The upper half accumulates; the lower half holds the unscanned multiplier bits.
    assign sum = {1'b0, prod_reg[MUL_P_W-1:MUL_B_W]} + (prod_reg[0] ? {1'b0, a_reg} : '0);
    assign prod_next = {sum, prod_reg[MUL_B_W-1:1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MUL_CNT_W'(MUL_B_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg    <= a;
            prod_reg <= {{MUL_A_W{1'b0}}, b};
        end
        else if (busy_reg)
            prod_reg <= prod_next;
    end

    assign done = done_reg;
    assign p    = prod_reg;

endmodule

// ===== rtl/stac_cordic.sv =====
// Iterative rotation-mode CORDIC giving sine and cosine in Q30, one step per cycle.
// Depends on stac_pkg.

module stac_cordic (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [stac_pkg::ANG_W-1:0]  z_in,
    output logic                               done,
    output logic signed [stac_pkg::ANG_W-1:0]  cos_out,
    output logic signed [stac_pkg::ANG_W-1:0]  sin_out
);
    import stac_pkg::*;

    logic                    busy_reg;
    logic                    done_reg;
    logic [ITER_W-1:0]       iter_reg;
    logic signed [ANG_W-1:0] x_reg;
    logic signed [ANG_W-1:0] y_reg;
    logic signed [ANG_W-1:0] z_reg;
    logic signed [ANG_W-1:0] dx;
    logic signed [ANG_W-1:0] dy;
    logic signed [ANG_W-1:0] at;

    assign dx = y_reg >>> iter_reg;
    assign dy = x_reg >>> iter_reg;
    assign at = $signed(atan_q30(5'(iter_reg)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
            end
            else if (busy_reg)
            begin
                iter_reg <= iter_reg + 1'b1;
                if (iter_reg == ITER_W'(CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= CORDIC_GAIN;
            y_reg <= '0;
            z_reg <= z_in;
        end
        else if (busy_reg)
        begin
            if (!z_reg[ANG_W-1])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + at;
            end
        end
    end

    assign done    = done_reg;
    assign cos_out = x_reg;
    assign sin_out = y_reg;

endmodule

// ===== rtl/stac_div100.sv =====
// Restoring divider by the constant 100, one quotient bit per cycle.
// Depends on stac_pkg.

module stac_div100 (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [stac_pkg::DIV_W-1:0]  n,
    output logic                        done,
    output logic [stac_pkg::DIV_W-1:0]  q
);
    import stac_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [REM_W:0]       trial;
    logic                 ge;

    // The dividend shifts out at the top while quotient bits enter at the bottom.
    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign ge    = (trial >= (REM_W + 1)'(CM_PER_M));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= n;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? REM_W'(trial - (REM_W + 1)'(CM_PER_M)) : trial[REM_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign q    = quo_reg;

endmodule

// ===== rtl/stac_checker.sv =====
// Port-level checks for the survey traverse accumulator, and the bind that attaches them.
// Depends on stac_pkg and on survey_traverse_accumulator_unit.

module stac_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic [1:0]                         point_kind,
    input logic signed [stac_pkg::POS_W-1:0]  pos_x,
    input logic signed [stac_pkg::POS_W-1:0]  pos_y,
    input logic signed [stac_pkg::POS_W-1:0]  pos_z,
    input logic [stac_pkg::CNT_W-1:0]         station_number
);
    import stac_pkg::*;

    // No result is offered in the cycle after reset has been seen.
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result offered during reset");

    // A stalled result request holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(point_kind) && $stable(pos_x)
            && $stable(pos_y) && $stable(pos_z) && $stable(station_number))
        else $error("stalled result changed");

    // A clear always reports the origin and station zero.
    a_clear_origin: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && point_kind == KIND_CLEAR |->
            pos_x == '0 && pos_y == '0 && pos_z == '0 && station_number == '0)
        else $error("clear result not at origin");

    // The unused kind never reaches the result channel.
    a_kind_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> point_kind == KIND_LEG || point_kind == KIND_SPLAY
            || point_kind == KIND_CLEAR)
        else $error("unused kind on result channel");

    // A leg always reaches a station numbered one or more.
    a_leg_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && point_kind == KIND_LEG |-> station_number != '0)
        else $error("leg reported station zero");

endmodule

bind survey_traverse_accumulator_unit stac_checker u_stac_checker (.*);

// ===== tb/survey_traverse_accumulator_unit_tb.sv =====
// Testbench for the survey traverse accumulator: directed and random survey shots.
// Predicts each point with its own CORDIC model; depends on stac_pkg and the block.

module survey_traverse_accumulator_unit_tb;
    import stac_pkg::*;

    typedef struct {
        logic [1:0]        kind;
        logic signed [39:0] x;
        logic signed [39:0] y;
        logic signed [39:0] z;
        logic [15:0]       num;
    } point_t;

    localparam longint POS_HI     = 64'sd549755813887;
    localparam longint POS_LO     = -64'sd549755813888;
    localparam longint LIMIT_CYC  = 3000000;
    localparam logic [1:0] KIND_NONE = 2'd3;

    class traverse_scoreboard;
        longint sx, sy, sz;
        int     count;
        point_t pending[$];
        int     errors;

        function new();
            sx = 0; sy = 0; sz = 0; count = 0; errors = 0;
        endfunction

        function longint rdiv(longint num, longint den);
            longint mag;
            longint q;
            mag = (num < 0) ? -num : num;
            q = (mag + den / 2) / den;
            return (num < 0) ? -q : q;
        endfunction

        function longint clamp40(longint v);
            if (v > POS_HI)
                return POS_HI;
            if (v < POS_LO)
                return POS_LO;
            return v;
        endfunction

        function longint atan_q(int i);
            longint tab[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                                33543516, 16775851, 8388437, 4194283, 2097149};
            if (i < 10)
                return tab[i];
            if (i <= 30)
                return longint'(1) << (30 - i);
            return 0;
        endfunction

        // Sine and cosine of an angle in hundredths of a degree, both Q30.
        function void trig(longint cdeg, output longint s, output longint c);
            longint r, xv, yv, zv, dx, dy;
            bit     flip;
            r = cdeg % 36000;
            flip = 0;
            if (r < 0)
                r += 36000;
            if (r > 18000)
                r -= 36000;
            if (r > 9000)
            begin
                r -= 18000;
                flip = 1;
            end
            else if (r < -9000)
            begin
                r += 18000;
                flip = 1;
            end
            zv = rdiv(r * 64'sd12281662764, 65536);
            xv = 652032874;
            yv = 0;
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                dx = yv >>> i;
                dy = xv >>> i;
                if (zv >= 0)
                begin
                    xv -= dx; yv += dy; zv -= atan_q(i);
                end
                else
                begin
                    xv += dx; yv -= dy; zv += atan_q(i);
                end
            end
            s = flip ? -yv : yv;
            c = flip ? -xv : xv;
        endfunction

        function void note_shot(logic [1:0] k, logic [15:0] d, logic signed [14:0] p,
                                logic [15:0] w);
            longint sp, cp, sw, cw, du, den, px, py, pz;
            point_t e;
            if (k == KIND_NONE)
                return;
            if (k == KIND_CLEAR)
            begin
                sx = 0; sy = 0; sz = 0; count = 0;
                px = 0; py = 0; pz = 0;
            end
            else
            begin
                trig(longint'(p), sp, cp);
                trig(longint'(w), sw, cw);
                du  = longint'(d) * 30;
                den = longint'(100) << (30 - COORD_FRAC_BITS);
                px = clamp40(sx + rdiv(du * rdiv(cp * cw, 64'sd1 << 30), den));
                py = clamp40(sy + rdiv(du * rdiv(cp * sw, 64'sd1 << 30), den));
                pz = clamp40(sz + rdiv(du * sp, den));
                if (k == KIND_LEG)
                begin
                    sx = px; sy = py; sz = pz;
                    if (count < 65535)
                        count++;
                end
            end
            e.kind = k; e.x = px[39:0]; e.y = py[39:0]; e.z = pz[39:0];
            e.num = count[15:0];
            pending.insert(pending.size(), e);
        endfunction

        function void check_point(point_t a);
            point_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: point_kind expected none actual %0d", $time, a.kind);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.kind !== e.kind)
            begin
                $display("%0t: point_kind expected %0d actual %0d", $time, e.kind, a.kind);
                errors++;
            end
            if (a.x !== e.x)
            begin
                $display("%0t: pos_x expected %0d actual %0d", $time, e.x, a.x);
                errors++;
            end
            if (a.y !== e.y)
            begin
                $display("%0t: pos_y expected %0d actual %0d", $time, e.y, a.y);
                errors++;
            end
            if (a.z !== e.z)
            begin
                $display("%0t: pos_z expected %0d actual %0d", $time, e.z, a.z);
                errors++;
            end
            if (a.num !== e.num)
            begin
                $display("%0t: station_number expected %0d actual %0d", $time, e.num, a.num);
                errors++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         kind = 2'd0;
    logic [15:0]        distance_cm = 16'd0;
    logic signed [14:0] pitch_cdeg = 15'sd0;
    logic [15:0]        yaw_cdeg = 16'd0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         point_kind;
    logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
    logic [CNT_W-1:0]   station_number;

    traverse_scoreboard sb = new();
    bit     calm = 0;
    bit     hold_req = 0;
    longint cycles = 0;

    survey_traverse_accumulator_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .distance_cm(distance_cm), .pitch_cdeg(pitch_cdeg),
        .yaw_cdeg(yaw_cdeg),
        .out_valid(out_valid), .out_stall(out_stall),
        .point_kind(point_kind), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .station_number(station_number)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYC)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Results are checked at the edge where they are taken.
    always @(posedge clk)
    begin
        point_t a;
        if (rst_n && out_valid && !out_stall)
        begin
            a.kind = point_kind; a.x = pos_x; a.y = pos_y; a.z = pos_z;
            a.num = station_number;
            sb.check_point(a);
        end
    end

    // Receiver back-pressure, with one long hold-off on request.
    initial
    begin
        int held;
        held = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req && held < 3000)
            begin
                out_stall <= 1'b1;
                held++;
            end
            else
                out_stall <= (!calm && $urandom_range(99) < 21);
        end
    end

    task automatic send_shot(logic [1:0] k, logic [15:0] d, logic [14:0] p, logic [15:0] w);
        if (!calm && $urandom_range(99) < 21)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= k;
        distance_cm <= d;
        pitch_cdeg  <= p;
        yaw_cdeg    <= w;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_shot(k, d, p, w);
    endtask

    initial
    begin
        logic [1:0] k;
        int         pick;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed shots: field extremes, every kind, angles past vertical and a full turn.
        send_shot(KIND_NONE, 16'hffff, 15'h7fff, 16'hffff);
        send_shot(KIND_LEG, 16'd0, 15'd0, 16'd0);
        send_shot(KIND_LEG, 16'd65535, 15'd0, 16'd0);
        send_shot(KIND_LEG, 16'd65535, 15'd9000, 16'd9000);
        send_shot(KIND_LEG, 16'd65535, -15'sd9000, 16'd27000);
        send_shot(KIND_SPLAY, 16'd1000, 15'sd16383, 16'd35999);
        send_shot(KIND_SPLAY, 16'd1000, -15'sd16384, 16'd36000);
        send_shot(KIND_SPLAY, 16'd1234, 15'sd9001, 16'd65535);
        send_shot(KIND_LEG, 16'd500, -15'sd9001, 16'd18000);
        send_shot(KIND_SPLAY, 16'd1, 15'sd4500, 16'd4500);
        send_shot(KIND_NONE, 16'd0, 15'd0, 16'd0);
        send_shot(KIND_CLEAR, 16'd777, 15'sd100, 16'd100);
        send_shot(KIND_SPLAY, 16'd300, 15'sd0, 16'd13500);
        send_shot(KIND_LEG, 16'd32768, -15'sd1, 16'd1);
        send_shot(KIND_CLEAR, 16'd0, 15'd0, 16'd0);

        // Random traverses: mostly legs and splays, the odd clear or unused kind.
        for (int n = 0; n < 1400; n++)
        begin
            if (n == 150)
                hold_req = 1;
            calm = (n >= 600 && n < 800);
            pick = $urandom_range(99);
            if (pick < 48)
                k = KIND_LEG;
            else if (pick < 88)
                k = KIND_SPLAY;
            else if (pick < 94)
                k = KIND_CLEAR;
            else
                k = KIND_NONE;
            if (k == KIND_NONE)
                n--;
            send_shot(k, 16'($urandom), 15'($urandom), 16'($urandom));
        end
        calm = 0;
        in_valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (500) @(posedge clk);
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/stac_pkg.sv
rtl/stac_mul.sv
rtl/stac_cordic.sv
rtl/stac_div100.sv
rtl/survey_traverse_accumulator_unit.sv
rtl/stac_checker.sv
tb/survey_traverse_accumulator_unit_tb.sv
